>>> hw/rtl/smm_pkg.sv
// Shared types and constants for the square matrix multiply block.
// Field widths, mode codes, controller states and the command struct.
// No dependencies; every other file imports this package.
package smm_pkg;

    localparam int ELEM_W      = 23;
    localparam int RESULT_W    = 50;
    localparam int MODE_W      = 2;
    localparam int IDX_FIELD_W = 6;
    localparam int CFG_W       = 7;

    localparam logic [CFG_W-1:0] SIZE_RESET = 7'd64;

    localparam logic [MODE_W-1:0] MODE_LOAD_A  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOAD_B  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ROW_REQ = 2'd2;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_ctrl_state;

    // Controller to datapath command for one cycle.
    typedef struct packed {
        logic issue;
        logic first_k;
        logic final_k;
        logic last_col;
        logic wr_a;
        logic wr_b;
    } t_dp_cmd;

    // Tag that rides along the multiply-accumulate pipeline.
    typedef struct packed {
        logic                   first_k;
        logic                   final_k;
        logic                   last_col;
        logic [IDX_FIELD_W-1:0] row;
    } t_mac_tag;

endpackage

>>> hw/rtl/smm_stream_if.sv
// Valid/ready channel interfaces for the input and result streams.
// Depends on smm_pkg for the payload field widths.
interface smm_in_if;
    import smm_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [MODE_W-1:0]        mode;
    logic [IDX_FIELD_W-1:0]   row_index;
    logic [IDX_FIELD_W-1:0]   col_index;
    logic signed [ELEM_W-1:0] element;

    modport source (output valid, mode, row_index, col_index, element, input ready);
    modport sink   (input valid, mode, row_index, col_index, element, output ready);
endinterface

interface smm_out_if;
    import smm_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [IDX_FIELD_W-1:0]     out_row;
    logic [IDX_FIELD_W-1:0]     out_col;
    logic signed [RESULT_W-1:0] product_value;
    logic                       last;

    modport source (output valid, out_row, out_col, product_value, last, input ready);
    modport sink   (input valid, out_row, out_col, product_value, last, output ready);
endinterface

>>> hw/rtl/square_matrix_multiply.sv
// Square matrix multiply, C = A * B, with the dimension n taken from the size register
// (0 acts as 1, values above MAX_DIM act as MAX_DIM). Elements are signed fixed point
// with 8 fraction bits; results are exact sums with 16 fraction bits, saturated to 50
// bits. A load transaction (mode 0 for A, 1 for B) writes one element; loads outside n
// are dropped. A row request issues n*n products, one multiply-accumulate issue per
// cycle unless stalled, from the single read port of each element memory; results
// of the row leave in column order, each through the read, product, sum and output
// registers, with last set on column n-1. The next transaction is accepted the cycle
// after the final product issues; a held result stalls the whole pipeline. Element
// memories are not cleared and need no clearing pass.
// Depends on smm_pkg, smm_stream_if, smm_ctrl and smm_dp.
module square_matrix_multiply #(
    parameter int MAX_DIM = 64
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    smm_in_if.sink                    i_in,
    smm_out_if.source                 o_out,
    input  logic                      i_cfg_wr_en,
    input  logic [smm_pkg::CFG_W-1:0] i_cfg_wr_data
);
    import smm_pkg::*;

    localparam int IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

    t_dp_cmd                    w_cmd;
    logic                       w_stall;
    logic                       w_in_ready;
    logic [IDX_FIELD_W-1:0]     w_row;
    logic [IDX_W-1:0]           w_j, w_k;
    logic                       w_out_valid;
    logic [IDX_FIELD_W-1:0]     w_out_row, w_out_col;
    logic signed [RESULT_W-1:0] w_out_value;
    logic                       w_out_last;

    smm_ctrl #(
        .MAX_DIM (MAX_DIM)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in.valid),
        .i_in_mode     (i_in.mode),
        .i_in_row      (i_in.row_index),
        .i_in_col      (i_in.col_index),
        .o_in_ready    (w_in_ready),
        .i_stall       (w_stall),
        .o_cmd         (w_cmd),
        .o_row         (w_row),
        .o_j           (w_j),
        .o_k           (w_k)
    );

    smm_dp #(
        .MAX_DIM (MAX_DIM)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_rd_row    (w_row),
        .i_rd_j      (w_j),
        .i_rd_k      (w_k),
        .i_wr_row    (i_in.row_index),
        .i_wr_col    (i_in.col_index),
        .i_wr_elem   (i_in.element),
        .o_stall     (w_stall),
        .o_out_valid (w_out_valid),
        .i_out_ready (o_out.ready),
        .o_out_row   (w_out_row),
        .o_out_col   (w_out_col),
        .o_out_value (w_out_value),
        .o_out_last  (w_out_last)
    );

    assign i_in.ready          = w_in_ready;
    assign o_out.valid         = w_out_valid;
    assign o_out.out_row       = w_out_row;
    assign o_out.out_col       = w_out_col;
    assign o_out.product_value = w_out_value;
    assign o_out.last          = w_out_last;

endmodule

>>> hw/rtl/smm_ctrl.sv
// Controller: size register, accept logic and the row-request sequencer.
// Walks column j and inner index k; depends on smm_pkg.
module smm_ctrl #(
    parameter int  MAX_DIM = 64,
    localparam int IDX_W   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [smm_pkg::CFG_W-1:0]      i_cfg_wr_data,
    input  logic                           i_in_valid,
    input  logic [smm_pkg::MODE_W-1:0]     i_in_mode,
    input  logic [smm_pkg::IDX_FIELD_W-1:0] i_in_row,
    input  logic [smm_pkg::IDX_FIELD_W-1:0] i_in_col,
    output logic                           o_in_ready,
    input  logic                           i_stall,
    output smm_pkg::t_dp_cmd               o_cmd,
    output logic [smm_pkg::IDX_FIELD_W-1:0] o_row,
    output logic [IDX_W-1:0]               o_j,
    output logic [IDX_W-1:0]               o_k
);
    import smm_pkg::*;

    localparam int CMP_W = IDX_W + IDX_FIELD_W;
    localparam logic [CMP_W-1:0] DIM_MAX = CMP_W'(MAX_DIM);

    t_ctrl_state             r_state, n_state;
    logic [CFG_W-1:0]        r_size;
    logic [IDX_FIELD_W-1:0]  r_row, n_row;
    logic [IDX_W-1:0]        r_j, n_j, r_k, n_k, r_last, n_last;
    logic [CMP_W-1:0]        w_size_ext, w_last_ext, w_row_ext, w_col_ext;
    logic                    w_row_ok, w_col_ok;

    // Clamp the configured size to 1..MAX_DIM and express it as the last index.
    always_comb begin
        w_size_ext = CMP_W'(r_size);
        if (w_size_ext == '0) begin
            w_last_ext = '0;
        end else if (w_size_ext > DIM_MAX) begin
            w_last_ext = DIM_MAX - CMP_W'(1);
        end else begin
            w_last_ext = w_size_ext - CMP_W'(1);
        end
    end

    assign w_row_ext = CMP_W'(i_in_row);
    assign w_col_ext = CMP_W'(i_in_col);
    assign w_row_ok  = (w_row_ext <= w_last_ext);
    assign w_col_ok  = (w_col_ext <= w_last_ext);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= SIZE_RESET;
        end else if (i_cfg_wr_en) begin
            r_size <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_row   <= '0;
            r_j     <= '0;
            r_k     <= '0;
            r_last  <= '0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
            r_j     <= n_j;
            r_k     <= n_k;
            r_last  <= n_last;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_row      = r_row;
        n_j        = r_j;
        n_k        = r_k;
        n_last     = r_last;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_in_mode == MODE_LOAD_A && w_row_ok && w_col_ok) begin
                        o_cmd.wr_a = 1'b1;
                    end
                    if (i_in_mode == MODE_LOAD_B && w_row_ok && w_col_ok) begin
                        o_cmd.wr_b = 1'b1;
                    end
                    if (i_in_mode == MODE_ROW_REQ && w_row_ok) begin
                        n_state = ST_RUN;
                        n_row   = i_in_row;
                        n_j     = '0;
                        n_k     = '0;
                        n_last  = w_last_ext[IDX_W-1:0];
                    end
                end
            end
            ST_RUN: begin
                o_cmd.issue    = 1'b1;
                o_cmd.first_k  = (r_k == '0);
                o_cmd.final_k  = (r_k == r_last);
                o_cmd.last_col = (r_j == r_last);
                // Hold the indices while the output side is stalled.
                if (!i_stall) begin
                    if (r_k == r_last) begin
                        n_k = '0;
                        n_j = r_j + IDX_W'(1);
                        if (r_j == r_last) begin
                            n_state = ST_IDLE;
                        end
                    end else begin
                        n_k = r_k + IDX_W'(1);
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_row = r_row;
    assign o_j   = r_j;
    assign o_k   = r_k;

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |-> (r_j <= r_last && r_k <= r_last))
        else $error("row sequencer index past the last column");

    a_wr_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.wr_a || o_cmd.wr_b) |-> (i_in_valid && o_in_ready && !(o_cmd.wr_a && o_cmd.wr_b)))
        else $error("store write without an accepted load transaction");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.issue && i_stall) |=> ($stable(r_j) && $stable(r_k) && r_state == ST_RUN))
        else $error("sequencer advanced during a stall");

    a_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.issue && o_cmd.final_k && o_cmd.last_col && !i_stall) |=> (r_state == ST_IDLE))
        else $error("sequencer did not return to idle after the final product");

endmodule

>>> hw/rtl/smm_dp.sv
// Datapath: A and B element memories and the multiply-accumulate pipeline
// (read, multiply, accumulate, saturate into the output register). Uses smm_pkg.
module smm_dp #(
    parameter int  MAX_DIM = 64,
    localparam int IDX_W   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  smm_pkg::t_dp_cmd                     i_cmd,
    input  logic [smm_pkg::IDX_FIELD_W-1:0]      i_rd_row,
    input  logic [IDX_W-1:0]                     i_rd_j,
    input  logic [IDX_W-1:0]                     i_rd_k,
    input  logic [smm_pkg::IDX_FIELD_W-1:0]      i_wr_row,
    input  logic [smm_pkg::IDX_FIELD_W-1:0]      i_wr_col,
    input  logic signed [smm_pkg::ELEM_W-1:0]    i_wr_elem,
    output logic                                 o_stall,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [smm_pkg::IDX_FIELD_W-1:0]      o_out_row,
    output logic [smm_pkg::IDX_FIELD_W-1:0]      o_out_col,
    output logic signed [smm_pkg::RESULT_W-1:0]  o_out_value,
    output logic                                 o_out_last
);
    import smm_pkg::*;

    localparam int DEPTH    = MAX_DIM * MAX_DIM;
    localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CMP_W    = IDX_W + IDX_FIELD_W;
    localparam int PROD_W   = 2 * ELEM_W;
    localparam int SUM_W    = PROD_W + $clog2(MAX_DIM);
    localparam int ACC_W    = (SUM_W > RESULT_W) ? SUM_W : RESULT_W + 1;
    localparam logic [ADDR_W-1:0] ROW_STRIDE = ADDR_W'(MAX_DIM);
    localparam logic signed [ACC_W-1:0] SAT_HI =
        {{(ACC_W-RESULT_W+1){1'b0}}, {(RESULT_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;

    logic signed [ELEM_W-1:0]   r_mem_a [0:DEPTH-1];
    logic signed [ELEM_W-1:0]   r_mem_b [0:DEPTH-1];
    logic signed [ELEM_W-1:0]   r_rd_a, r_rd_b;
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [ACC_W-1:0]    r_acc;
    logic signed [RESULT_W-1:0] w_sat, r_out_val;

    logic                    r_s1_vld, r_s2_vld, r_s3_done, r_out_vld;
    t_mac_tag                w_tag0, r_s1_tag, r_s2_tag;
    logic [IDX_W-1:0]        r_s1_col, r_s2_col, r_s3_col;
    logic [IDX_FIELD_W-1:0]  r_s3_row, r_out_row, r_out_col;
    logic                    r_s3_lastc, r_out_last;

    logic [CMP_W-1:0]        w_rd_row_ext, w_wr_row_ext, w_wr_col_ext, w_s3_col_ext;
    logic [IDX_W-1:0]        w_rd_row, w_wr_row, w_wr_col;
    logic [ADDR_W-1:0]       w_addr_a, w_addr_b, w_addr_wr;
    logic                    w_adv;

    assign w_rd_row_ext = CMP_W'(i_rd_row);
    assign w_wr_row_ext = CMP_W'(i_wr_row);
    assign w_wr_col_ext = CMP_W'(i_wr_col);
    assign w_s3_col_ext = CMP_W'(r_s3_col);
    assign w_rd_row     = w_rd_row_ext[IDX_W-1:0];
    assign w_wr_row     = w_wr_row_ext[IDX_W-1:0];
    assign w_wr_col     = w_wr_col_ext[IDX_W-1:0];

    // Row-major addressing: A is read along row, B down column j.
    assign w_addr_a  = ADDR_W'(w_rd_row) * ROW_STRIDE + ADDR_W'(i_rd_k);
    assign w_addr_b  = ADDR_W'(i_rd_k) * ROW_STRIDE + ADDR_W'(i_rd_j);
    assign w_addr_wr = ADDR_W'(w_wr_row) * ROW_STRIDE + ADDR_W'(w_wr_col);

    // The whole pipeline holds while a finished result waits to be taken.
    assign w_adv   = !(r_out_vld && !i_out_ready);
    assign o_stall = !w_adv;

    assign w_tag0.first_k  = i_cmd.first_k;
    assign w_tag0.final_k  = i_cmd.final_k;
    assign w_tag0.last_col = i_cmd.last_col;
    assign w_tag0.row      = i_rd_row;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_a) begin
            r_mem_a[w_addr_wr] <= i_wr_elem;
        end
        if (w_adv) begin
            r_rd_a <= r_mem_a[w_addr_a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_b) begin
            r_mem_b[w_addr_wr] <= i_wr_elem;
        end
        if (w_adv) begin
            r_rd_b <= r_mem_b[w_addr_b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_s3_done <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_s1_vld  <= i_cmd.issue;
            r_s2_vld  <= r_s1_vld;
            r_s3_done <= r_s2_vld && r_s2_tag.final_k;
            r_out_vld <= r_s3_done;
        end
    end

    always_comb begin
        if (r_acc > SAT_HI) begin
            w_sat = SAT_HI[RESULT_W-1:0];
        end else if (r_acc < SAT_LO) begin
            w_sat = SAT_LO[RESULT_W-1:0];
        end else begin
            w_sat = r_acc[RESULT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_tag   <= w_tag0;
            r_s1_col   <= i_rd_j;
            r_s2_tag   <= r_s1_tag;
            r_s2_col   <= r_s1_col;
            r_prod     <= r_rd_a * r_rd_b;
            // Restart the sum on the first product of each column.
            if (r_s2_vld) begin
                if (r_s2_tag.first_k) begin
                    r_acc <= ACC_W'(r_prod);
                end else begin
                    r_acc <= r_acc + ACC_W'(r_prod);
                end
            end
            r_s3_row   <= r_s2_tag.row;
            r_s3_col   <= r_s2_col;
            r_s3_lastc <= r_s2_tag.last_col;
            if (r_s3_done) begin
                r_out_row  <= r_s3_row;
                r_out_col  <= w_s3_col_ext[IDX_FIELD_W-1:0];
                r_out_val  <= w_sat;
                r_out_last <= r_s3_lastc;
            end
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_row   = r_out_row;
    assign o_out_col   = r_out_col;
    assign o_out_value = r_out_val;
    assign o_out_last  = r_out_last;

    a_pipe_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !i_out_ready) |=>
            ($stable({r_s1_vld, r_s2_vld, r_s3_done}) && r_out_vld))
        else $error("pipeline moved while the output register was stalled");

    a_col_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_s2_vld && r_s2_tag.final_k) |=> r_s3_done)
        else $error("final product of a column did not close the sum");

    a_no_rw_mix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.issue && (i_cmd.wr_a || i_cmd.wr_b)))
        else $error("store write during a product run");

endmodule

>>> dv/square_matrix_multiply_scoreboard.sv
`timescale 1ns / 1ps
// Scoreboard for square_matrix_multiply: keeps its own copy of both matrices and the size,
// predicts every product row requested and checks the result stream in order.
// Depends on smm_pkg and the stream interfaces in smm_stream_if.
module square_matrix_multiply_scoreboard #(
    parameter int MAX_DIM = 64
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    smm_in_if                         i_in,
    smm_out_if                        i_out,
    input  logic                      i_cfg_wr_en,
    input  logic [smm_pkg::CFG_W-1:0] i_cfg_wr_data,
    output int                        o_fail_count,
    output int                        o_pending,
    output int                        o_checked
);
    import smm_pkg::*;

    localparam longint SUM_HI = (longint'(1) <<< (RESULT_W - 1)) - 1;
    localparam longint SUM_LO = -SUM_HI - 1;

    typedef struct packed {
        logic [IDX_FIELD_W-1:0]     row;
        logic [IDX_FIELD_W-1:0]     col;
        logic signed [RESULT_W-1:0] value;
        logic                       last;
    } t_product_elem;

    logic signed [ELEM_W-1:0] a_elems [MAX_DIM*MAX_DIM];
    logic signed [ELEM_W-1:0] b_elems [MAX_DIM*MAX_DIM];
    logic [CFG_W-1:0]         size_reg;
    t_product_elem            product_q [$];
    int                       fail_total = 0;
    int                       checked_total = 0;

    initial begin
        foreach (a_elems[i]) begin
            a_elems[i] = '0;
            b_elems[i] = '0;
        end
    end

    function automatic int dim_of(input logic [CFG_W-1:0] size);
        if (size == 0)
            return 1;
        if (size > MAX_DIM)
            return MAX_DIM;
        return int'(size);
    endfunction

    // Apply one accepted transaction: store a load, or queue the whole product row.
    task automatic compute_product_row(input logic [MODE_W-1:0] mode,
                                       input logic [IDX_FIELD_W-1:0] row,
                                       input logic [IDX_FIELD_W-1:0] col,
                                       input logic signed [ELEM_W-1:0] value);
        int            n;
        longint        acc;
        t_product_elem elem;
        n = dim_of(size_reg);
        if ((mode == MODE_LOAD_A || mode == MODE_LOAD_B) && int'(row) < n && int'(col) < n) begin
            if (mode == MODE_LOAD_A)
                a_elems[int'(row) * MAX_DIM + int'(col)] = value;
            else
                b_elems[int'(row) * MAX_DIM + int'(col)] = value;
        end else if (mode == MODE_ROW_REQ && int'(row) < n) begin
            for (int j = 0; j < n; j++) begin
                acc = 0;
                for (int k = 0; k < n; k++)
                    acc += longint'(a_elems[int'(row) * MAX_DIM + k])
                         * longint'(b_elems[k * MAX_DIM + j]);
                if (acc > SUM_HI)
                    acc = SUM_HI;
                if (acc < SUM_LO)
                    acc = SUM_LO;
                elem.row   = row;
                elem.col   = IDX_FIELD_W'(j);
                elem.value = acc[RESULT_W-1:0];
                elem.last  = (j == n - 1);
                product_q.push_back(elem);
            end
        end
    endtask

    task automatic check_product();
        t_product_elem want;
        if (product_q.size() == 0) begin
            fail_total++;
            if (fail_total <= 10)
                $display("%0t: unexpected result row %0d col %0d value %0d last %0b",
                         $time, i_out.out_row, i_out.out_col,
                         $signed(i_out.product_value), i_out.last);
            return;
        end
        want = product_q.pop_front();
        checked_total++;
        if (i_out.out_row !== want.row || i_out.out_col !== want.col
                || i_out.product_value !== want.value || i_out.last !== want.last) begin
            fail_total++;
            if (fail_total <= 10) begin
                $display("%0t: expected row %0d col %0d value %0d last %0b", $time,
                         want.row, want.col, $signed(want.value), want.last);
                $display("%0t:      got row %0d col %0d value %0d last %0b", $time,
                         i_out.out_row, i_out.out_col, $signed(i_out.product_value),
                         i_out.last);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            size_reg = SIZE_RESET;
        end else begin
            if (i_out.valid && i_out.ready)
                check_product();
            if (i_in.valid && i_in.ready)
                compute_product_row(i_in.mode, i_in.row_index, i_in.col_index, i_in.element);
            if (i_cfg_wr_en)
                size_reg = i_cfg_wr_data;
        end
        o_pending    <= product_q.size();
        o_fail_count <= fail_total;
        o_checked    <= checked_total;
    end

endmodule

>>> dv/square_matrix_multiply_tb.sv
`timescale 1ns / 1ps
// Testbench top for square_matrix_multiply: drives loads, row requests and the size register
// through directed and random phases with varied idling, and reports the verdict.
// Depends on smm_pkg, smm_stream_if, the block and square_matrix_multiply_scoreboard.
module square_matrix_multiply_tb;
    import smm_pkg::*;

    localparam int MAX_DIM = 64;
    localparam int ITEMS_PER_PHASE = 26;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam logic signed [ELEM_W-1:0] ELEM_MIN = {1'b1, {(ELEM_W-1){1'b0}}};
    localparam logic signed [ELEM_W-1:0] ELEM_MAX = {1'b0, {(ELEM_W-1){1'b1}}};
    localparam logic signed [ELEM_W-1:0] ELEM_ONE = ELEM_W'(1);

    logic             i_clk;
    logic             i_rst_n;
    logic             cfg_wr_en;
    logic [CFG_W-1:0] cfg_wr_data;
    int               fail_count;
    int               pending;
    int               checked;
    int               tx_idle_pct = 0;
    int               rx_stall_pct = 0;
    int               rx_hold_left = 0;
    int               dim = MAX_DIM;
    int               sent = 0;

    smm_in_if  in_ch ();
    smm_out_if out_ch ();

    square_matrix_multiply #(
        .MAX_DIM(MAX_DIM)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .o_out        (out_ch),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_wr_data(cfg_wr_data)
    );

    square_matrix_multiply_scoreboard #(
        .MAX_DIM(MAX_DIM)
    ) product_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_wr_data(cfg_wr_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #1_000_000;
        $display("square_matrix_multiply test failed");
        $finish;
    end

    // Result-side ready: a long hold-off when requested, else random stalls.
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_left > 0) begin
                rx_hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    function automatic logic signed [ELEM_W-1:0] rand_elem();
        case ($urandom_range(9))
            0: return ELEM_MIN;
            1: return ELEM_MAX;
            2: return '0;
            3: return '1;
            default: return ELEM_W'($urandom);
        endcase
    endfunction

    task automatic send(input logic [MODE_W-1:0] mode, input int row, input int col,
                        input logic signed [ELEM_W-1:0] value);
        while ($urandom_range(99) < tx_idle_pct) begin
            @(negedge i_clk);
            in_ch.valid <= 1'b0;
        end
        @(negedge i_clk);
        in_ch.valid     <= 1'b1;
        in_ch.mode      <= mode;
        in_ch.row_index <= IDX_FIELD_W'(row);
        in_ch.col_index <= IDX_FIELD_W'(col);
        in_ch.element   <= value;
        do @(posedge i_clk); while (!in_ch.ready);
        sent++;
    endtask

    // Drop valid and wait out every pending result.
    task automatic wait_for_products();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (pending != 0)
            @(posedge i_clk);
        repeat (dim * dim + 16) @(posedge i_clk);
    endtask

    task automatic write_size(input int value);
        @(negedge i_clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= CFG_W'(value);
        @(negedge i_clk);
        cfg_wr_en   <= 1'b0;
        dim = (value < 1) ? 1 : ((value > MAX_DIM) ? MAX_DIM : value);
    endtask

    // Load every in-range element first so that no request reads an unwritten entry.
    task automatic random_traffic(input int count, input bit pause_midway,
                                  input bit hold_receiver);
        int done;
        int pick;
        int row;
        int col;
        bit paused;
        for (int r = 0; r < dim; r++) begin
            for (int c = 0; c < dim; c++) begin
                send(MODE_LOAD_A, r, c, rand_elem());
                send(MODE_LOAD_B, r, c, rand_elem());
            end
        end
        if (hold_receiver)
            rx_hold_left = 400;
        done   = 0;
        paused = 1'b0;
        while (done < count) begin
            if (pause_midway && !paused && done == count / 2) begin
                wait_for_products();
                paused = 1'b1;
            end
            pick = $urandom_range(99);
            if (pick < 45) begin
                send(MODE_ROW_REQ, $urandom_range(dim - 1), $urandom_range(63), rand_elem());
                done++;
            end else if (pick < 75) begin
                send((pick < 60) ? MODE_LOAD_A : MODE_LOAD_B, $urandom_range(dim - 1),
                     $urandom_range(dim - 1), rand_elem());
                done++;
            end else if (pick < 85) begin
                // Out-of-range requests and loads: the block must drop them.
                row = $urandom_range(63, dim);
                col = $urandom_range(63);
                case ($urandom_range(2))
                    0: send(MODE_ROW_REQ, row, col, rand_elem());
                    1: send(MODE_LOAD_A, row, col, rand_elem());
                    default: send(MODE_LOAD_B, col, row, rand_elem());
                endcase
            end else begin
                send(MODE_UNUSED, $urandom_range(63), $urandom_range(63), rand_elem());
            end
        end
    endtask

    initial begin
        in_ch.valid     = 1'b0;
        in_ch.mode      = MODE_LOAD_A;
        in_ch.row_index = '0;
        in_ch.col_index = '0;
        in_ch.element   = '0;
        cfg_wr_en       = 1'b0;
        cfg_wr_data     = '0;
        i_rst_n         = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Size zero acts as one; extreme products and dropped transactions.
        tx_idle_pct  = 38;
        rx_stall_pct = 38;
        write_size(0);
        send(MODE_LOAD_A, 0, 0, ELEM_MIN);
        send(MODE_LOAD_B, 0, 0, ELEM_MIN);
        send(MODE_ROW_REQ, 0, 0, '0);
        send(MODE_LOAD_A, 1, 0, ELEM_ONE);
        send(MODE_LOAD_B, 0, 1, ELEM_ONE);
        send(MODE_ROW_REQ, 1, 0, '0);
        send(MODE_UNUSED, 0, 0, ELEM_MAX);
        send(MODE_LOAD_A, 0, 0, ELEM_MAX);
        send(MODE_ROW_REQ, 0, 0, '0);
        wait_for_products();

        write_size(2);
        send(MODE_LOAD_A, 0, 0, '1);
        send(MODE_LOAD_A, 0, 1, ELEM_MAX);
        send(MODE_LOAD_A, 1, 0, '0);
        send(MODE_LOAD_A, 1, 1, ELEM_ONE);
        send(MODE_LOAD_B, 0, 0, ELEM_MIN);
        send(MODE_LOAD_B, 0, 1, '1);
        send(MODE_LOAD_B, 1, 0, ELEM_MAX);
        send(MODE_LOAD_B, 1, 1, '0);
        send(MODE_ROW_REQ, 1, 0, '0);
        send(MODE_ROW_REQ, 0, 0, '0);
        wait_for_products();

        // Full size: column 0 saturates high and column 1 low on row 0.
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        write_size(MAX_DIM);
        for (int k = 0; k < MAX_DIM; k++)
            for (int j = 0; j < MAX_DIM; j++)
                send(MODE_LOAD_B, k, j,
                     (j == 0) ? ELEM_MIN : ((j == 1) ? ELEM_MAX : rand_elem()));
        for (int k = 0; k < MAX_DIM; k++) begin
            send(MODE_LOAD_A, 0, k, ELEM_MIN);
            send(MODE_LOAD_A, MAX_DIM - 1, k, rand_elem());
        end
        send(MODE_ROW_REQ, 0, 0, '0);
        send(MODE_ROW_REQ, MAX_DIM - 1, MAX_DIM - 1, ELEM_MAX);
        wait_for_products();

        // Largest register value clamps to the full size.
        write_size((1 << CFG_W) - 1);
        send(MODE_UNUSED, MAX_DIM - 1, MAX_DIM - 1, ELEM_MIN);
        send(MODE_ROW_REQ, MAX_DIM - 1, 0, '0);
        send(MODE_ROW_REQ, 0, MAX_DIM - 1, '0);
        wait_for_products();

        write_size(3);
        random_traffic(ITEMS_PER_PHASE, 1'b0, 1'b0);
        wait_for_products();

        tx_idle_pct = 50;
        write_size(8);
        random_traffic(ITEMS_PER_PHASE, 1'b1, 1'b0);
        wait_for_products();

        tx_idle_pct  = 0;
        rx_stall_pct = 50;
        write_size(5);
        random_traffic(ITEMS_PER_PHASE, 1'b0, 1'b1);
        wait_for_products();

        tx_idle_pct  = 38;
        rx_stall_pct = 38;
        write_size(1);
        random_traffic(ITEMS_PER_PHASE, 1'b0, 1'b0);
        wait_for_products();

        write_size(7);
        random_traffic(ITEMS_PER_PHASE, 1'b0, 1'b0);
        wait_for_products();

        $display("Sizes 1 to %0d incl. clamped register values and both saturation bounds:",
                 MAX_DIM);
        $display("%0d transactions sent, %0d product elements checked.", sent, checked);
        if (fail_count == 0) begin
            $display("square_matrix_multiply test passed");
        end else begin
            $display("square_matrix_multiply test failed");
        end
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/smm_pkg.sv
hw/rtl/smm_stream_if.sv
hw/rtl/smm_ctrl.sv
hw/rtl/smm_dp.sv
hw/rtl/square_matrix_multiply.sv
dv/square_matrix_multiply_scoreboard.sv
dv/square_matrix_multiply_tb.sv
